[src/tea_pkg.sv]
// Shared constants and widths for the trace averager.
package tea_pkg;

	localparam int TRACE_POINTS = 1024;
	localparam int SLOTS = 2 * TRACE_POINTS;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int POINT_W = 10;
	localparam int SAMPLE_W = 8;
	localparam int ACC_W = 16;
	localparam int SHIFT_W = 4;
	localparam int COUNT_W = 9;

	localparam logic [POINT_W:0] POINT_LIMIT = (POINT_W + 1)'(TRACE_POINTS);
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(8);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_RESTART = 1'b1
	} command_t;

endpackage

[src/tea_in_if.sv]
// Input item channel: sample for one channel and point, or a restart command.
interface tea_in_if
	import tea_pkg::*;
;
	logic valid;
	logic ready;
	logic command;
	logic channel;
	logic [POINT_W-1:0] point_index;
	logic [SAMPLE_W-1:0] sample;
	logic last_of_trace;

	modport source(output valid, command, channel, point_index, sample, last_of_trace,
		input ready);
	modport sink(input valid, command, channel, point_index, sample, last_of_trace,
		output ready);
endinterface

[src/tea_out_if.sv]
// Result item channel: averaged sample with its channel and point.
interface tea_out_if
	import tea_pkg::*;
;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] averaged_sample;
	logic out_channel;
	logic [POINT_W-1:0] out_index;

	modport source(output valid, averaged_sample, out_channel, out_index, input ready);
	modport sink(input valid, averaged_sample, out_channel, out_index, output ready);
endinterface

[src/tea_cfg_if.sv]
// Configuration write channel carrying the averaging shift.
interface tea_cfg_if
	import tea_pkg::*;
;
	logic valid;
	logic ready;
	logic [SHIFT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

[src/tea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tea_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

[src/trace_ema_averager.sv]
// Top level of the per-point, two-channel trace averager.
//
//   channel   role     carries
//   samples   sink     command, channel, point_index, sample, last_of_trace
//   results   source   averaged_sample, out_channel, out_index
//   cfg       sink     average_shift (always ready)
//
// One item per clock while results are not stalled. An item's accumulator read
// starts at acceptance, when the item is registered into stage s1; the update,
// write-back and result register load happen when it leaves stage s1. A write
// that collides with the next read is forwarded. Reset clears the trace counts,
// the shift and the valid flags; the accumulator RAM is not cleared. A stalled
// result holds the pending item in place and input is refused only while both
// are full.
module trace_ema_averager
	import tea_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tea_in_if.sink samples,
	tea_out_if.source results,
	tea_cfg_if.sink cfg
);

	logic [SHIFT_W-1:0] shift_q;
	logic [COUNT_W-1:0] count_q [2];

	logic valid_s1;
	logic command_s1;
	logic channel_s1;
	logic [POINT_W-1:0] point_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic last_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic hit_s1;
	logic [ACC_W-1:0] byp_s1;

	logic out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic out_channel_q;
	logic [POINT_W-1:0] out_index_q;

	logic accept;
	logic [SLOT_W-1:0] in_slot;
	logic in_range_s1;
	logic produce_s1;
	logic out_free;
	logic adv_s1;
	logic wr_en;
	logic [ACC_W-1:0] rd_data;
	logic [ACC_W-1:0] acc_old;
	logic [ACC_W-1:0] acc_new;
	logic [SAMPLE_W-1:0] result;
	logic [SHIFT_W-1:0] sh;
	logic [COUNT_W-1:0] count;
	logic [COUNT_W:0] fill_len;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg.valid) begin
			shift_q <= cfg.data;
		end
	end

	assign in_slot = SLOT_W'(samples.point_index) +
		(samples.channel ? SLOT_W'(TRACE_POINTS) : SLOT_W'(0));

	assign out_free = !out_valid_q || results.ready;
	assign in_range_s1 = {1'b0, point_s1} < POINT_LIMIT;
	assign produce_s1 = (command_s1 == CMD_SAMPLE) && in_range_s1;
	assign adv_s1 = valid_s1 && (!produce_s1 || out_free);
	assign samples.ready = !valid_s1 || adv_s1;
	assign accept = samples.valid && samples.ready;
	assign wr_en = adv_s1 && produce_s1;

	tea_ram #(
		.WIDTH(ACC_W),
		.DEPTH(SLOTS)
	) u_acc_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_s1),
		.wdata(acc_new),
		.re   (accept),
		.raddr(in_slot),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// The RAM misses a write landing on the same edge as the read, so the
	// written value is captured here for the following item.
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= samples.command;
			channel_s1 <= samples.channel;
			point_s1 <= samples.point_index;
			sample_s1 <= samples.sample;
			last_s1 <= samples.last_of_trace;
			slot_s1 <= in_slot;
			hit_s1 <= wr_en && (slot_s1 == in_slot);
			byp_s1 <= acc_new;
		end
	end

	always_comb begin
		sh = (shift_q > SHIFT_MAX) ? SHIFT_MAX : shift_q;
		count = count_q[channel_s1];
		fill_len = (COUNT_W + 1)'(1) << sh;
		acc_old = hit_s1 ? byp_s1 : rd_data;
		if (count == '0) begin
			acc_new = ACC_W'(sample_s1);
			result = sample_s1;
		end else if ({1'b0, count} < fill_len) begin
			acc_new = acc_old + ACC_W'(sample_s1);
			result = sample_s1;
		end else begin
			acc_new = acc_old - (acc_old >> sh) + ACC_W'(sample_s1);
			result = SAMPLE_W'(acc_new >> sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0] <= '0;
			count_q[1] <= '0;
		end else if (adv_s1) begin
			if (command_s1 == CMD_RESTART) begin
				count_q[0] <= '0;
				count_q[1] <= '0;
			end else if (in_range_s1 && last_s1 && (count != COUNT_MAX)) begin
				count_q[channel_s1] <= count + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_sample_q <= result;
			out_channel_q <= channel_s1;
			out_index_q <= point_s1;
		end
	end

	assign results.valid = out_valid_q;
	assign results.averaged_sample = out_sample_q;
	assign results.out_channel = out_channel_q;
	assign results.out_index = out_index_q;

endmodule

[tb/trace_ema_averager_check.sv]
// Checker for the trace averager: predicts each result and compares it with the block's output.
module trace_ema_averager_check
	import tea_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tea_in_if samples,
	tea_out_if results,
	tea_cfg_if cfg,
	output int mismatch_count,
	output int results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic channel;
		logic [POINT_W-1:0] index;
	} average_t;

	logic [ACC_W-1:0] point_sums [SLOTS];
	logic [COUNT_W-1:0] traces_done [2];
	logic [SHIFT_W-1:0] shift_setting;
	average_t averages_owed [$];
	average_t oldest;

	function automatic void average_point(input command_t cmd, input logic ch,
			input logic [POINT_W-1:0] pt, input logic [SAMPLE_W-1:0] smp, input logic last);
		logic [SHIFT_W-1:0] sh;
		logic [COUNT_W-1:0] cnt;
		logic [SLOT_W-1:0] slot;
		logic [ACC_W-1:0] acc;
		average_t due_now;
		if (cmd == CMD_RESTART) begin
			traces_done[0] = '0;
			traces_done[1] = '0;
			return;
		end
		if (int'(pt) >= TRACE_POINTS)
			return;
		sh = (shift_setting > SHIFT_MAX) ? SHIFT_MAX : shift_setting;
		cnt = traces_done[ch];
		slot = {ch, pt};
		due_now.value = smp;
		if (cnt == '0) begin
			acc = ACC_W'(smp);
		end else if (int'(cnt) < (1 << sh)) begin
			// Still filling: sum the traces and pass the raw sample through.
			acc = point_sums[slot] + ACC_W'(smp);
		end else begin
			acc = point_sums[slot] - (point_sums[slot] >> sh) + ACC_W'(smp);
			due_now.value = SAMPLE_W'(acc >> sh);
		end
		point_sums[slot] = acc;
		if (last && cnt != COUNT_MAX)
			traces_done[ch] = cnt + 1'b1;
		due_now.channel = ch;
		due_now.index = pt;
		averages_owed.push_back(due_now);
	endfunction

	function automatic void check_field(input string field, input logic [POINT_W-1:0] want,
			input logic [POINT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			averages_owed.delete();
			traces_done[0] = '0;
			traces_done[1] = '0;
			shift_setting = '0;
		end else begin
			if (results.valid && results.ready) begin
				if (averages_owed.size() == 0) begin
					$error("unexpected result: averaged_sample %0d, out_channel %0d, out_index %0d",
						results.averaged_sample, results.out_channel, results.out_index);
					mismatch_count++;
				end else begin
					oldest = averages_owed.pop_front();
					check_field("averaged_sample", POINT_W'(oldest.value),
						POINT_W'(results.averaged_sample));
					check_field("out_channel", POINT_W'(oldest.channel),
						POINT_W'(results.out_channel));
					check_field("out_index", oldest.index, results.out_index);
				end
			end
			if (cfg.valid && cfg.ready)
				shift_setting = cfg.data;
			if (samples.valid && samples.ready)
				average_point(command_t'(samples.command), samples.channel, samples.point_index,
					samples.sample, samples.last_of_trace);
		end
		results_owed = averages_owed.size();
	end

endmodule

[tb/trace_ema_averager_tb.sv]
// Testbench top for the trace averager: clock, reset, stimulus, watchdog and verdict.
module trace_ema_averager_tb
	import tea_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [POINT_W-1:0] LAST_POINT = POINT_W'(TRACE_POINTS - 1);

	logic clk;
	logic arst_n;
	int mismatch_count;
	int results_owed;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int items_sent = 0;

	// Stimulus-side view of the counts, so no unwritten accumulator is ever read.
	int traces_begun [2];
	bit point_loaded [SLOTS];
	logic [POINT_W-1:0] recent_point [2];

	tea_in_if samples_bus ();
	tea_out_if results_bus ();
	tea_cfg_if cfg_bus ();

	trace_ema_averager dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_bus),
		.results(results_bus),
		.cfg(cfg_bus)
	);

	trace_ema_averager_check result_check (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_bus),
		.results(results_bus),
		.cfg(cfg_bus),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		results_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			results_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((samples_bus.valid && samples_bus.ready) || (results_bus.valid && results_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL trace_ema_averager");
		$finish;
	end

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input command_t cmd, input logic ch, input logic [POINT_W-1:0] pt,
			input logic [SAMPLE_W-1:0] smp, input logic last);
		if (cmd == CMD_SAMPLE && traces_begun[ch] != 0 && !point_loaded[{ch, pt}])
			pt = recent_point[ch];
		while ($urandom_range(99) < sender_idle_pct) begin
			samples_bus.valid <= 1'b0;
			@(negedge clk);
		end
		samples_bus.valid <= 1'b1;
		samples_bus.command <= cmd;
		samples_bus.channel <= ch;
		samples_bus.point_index <= pt;
		samples_bus.sample <= smp;
		samples_bus.last_of_trace <= last;
		do @(posedge clk); while (!samples_bus.ready);
		@(negedge clk);
		items_sent++;
		if (cmd == CMD_RESTART) begin
			traces_begun[0] = 0;
			traces_begun[1] = 0;
		end else begin
			point_loaded[{ch, pt}] = 1'b1;
			recent_point[ch] = pt;
			if (last && traces_begun[ch] < int'(COUNT_MAX))
				traces_begun[ch]++;
		end
	endtask

	// Stop sending and let every owed result come out before going on.
	task automatic drain();
		samples_bus.valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_shift(input logic [SHIFT_W-1:0] value);
		drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Averaging runs: a restart, then whole traces over a small window per channel,
	// with stray items and traces that break off before their last sample.
	task automatic average_runs(input int item_goal, input int max_len, input int max_traces);
		int win_base [2];
		int win_len [2];
		int traces;
		logic ch;
		while (items_sent < item_goal) begin
			send_item(CMD_RESTART, 1'($urandom_range(1)), POINT_W'($urandom), SAMPLE_W'($urandom),
				1'($urandom_range(1)));
			for (int c = 0; c < 2; c++) begin
				win_len[c] = $urandom_range(1, max_len);
				win_base[c] = $urandom_range(0, TRACE_POINTS - win_len[c]);
			end
			traces = $urandom_range(1, max_traces);
			for (int t = 0; t < traces; t++) begin
				ch = 1'($urandom_range(1));
				for (int p = 0; p < win_len[ch]; p++) begin
					if ($urandom_range(15) == 0)
						send_item(command_t'($urandom_range(7) == 0), 1'($urandom_range(1)),
							POINT_W'($urandom), rand_sample(), 1'($urandom_range(1)));
					if ($urandom_range(63) == 0)
						break;
					send_item(CMD_SAMPLE, ch, POINT_W'(win_base[ch] + p), rand_sample(),
						p == win_len[ch] - 1);
				end
			end
		end
	endtask

	initial begin
		logic [POINT_W-1:0] spot [2];
		logic pick;
		arst_n = 1'b0;
		samples_bus.valid = 1'b0;
		samples_bus.command = CMD_SAMPLE;
		samples_bus.channel = 1'b0;
		samples_bus.point_index = '0;
		samples_bus.sample = '0;
		samples_bus.last_of_trace = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under a shift of two: first-trace load, fill, steady state,
		// back-to-back hits on one point, field extremes and a restart.
		write_shift(SHIFT_W'(2));
		send_item(CMD_SAMPLE, 1'b0, '0, 8'd0, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd255, 1'b1);
		send_item(CMD_SAMPLE, 1'b1, '0, 8'd255, 1'b0);
		send_item(CMD_SAMPLE, 1'b1, LAST_POINT, 8'd0, 1'b1);
		repeat (3) send_item(CMD_SAMPLE, 1'b0, '0, 8'd255, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd255, 1'b1);
		send_item(CMD_SAMPLE, 1'b0, '0, 8'd255, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd255, 1'b1);
		send_item(CMD_SAMPLE, 1'b0, '0, 8'd128, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd0, 1'b1);
		send_item(CMD_SAMPLE, 1'b0, '0, 8'd0, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, '0, 8'd0, 1'b0);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd255, 1'b1);
		// A restart ignores its other fields, so they are all set here.
		send_item(CMD_RESTART, 1'b1, LAST_POINT, 8'd255, 1'b1);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd128, 1'b1);
		send_item(CMD_SAMPLE, 1'b0, LAST_POINT, 8'd1, 1'b0);
		send_item(CMD_SAMPLE, 1'b1, 10'd512, 8'd170, 1'b0);
		send_item(CMD_SAMPLE, 1'b1, 10'd341, 8'd85, 1'b1);
		send_item(CMD_SAMPLE, 1'b1, 10'd512, 8'd255, 1'b0);

		average_runs(160, 12, 10);
		write_shift(SHIFT_W'(0));
		average_runs(240, 8, 4);

		// Single-point traces push channel 0's count past saturation, channel 1's only partway;
		// the shift then goes above eight and back to zero with channel 0's count still full.
		sender_idle_pct = 86;
		write_shift(SHIFT_W'(8));
		spot[0] = POINT_W'($urandom);
		spot[1] = POINT_W'($urandom);
		send_item(CMD_RESTART, 1'b0, '0, '0, 1'b0);
		for (int n = 0; n < 520; n++) begin
			send_item(CMD_SAMPLE, 1'b0, spot[0], rand_sample(), 1'b1);
			if (n % 10 == 0)
				send_item(CMD_SAMPLE, 1'b1, spot[1], rand_sample(), 1'b1);
		end
		for (int k = 0; k < 2; k++) begin
			write_shift((k == 0) ? SHIFT_W'(12) : SHIFT_W'(0));
			repeat (20) begin
				pick = 1'($urandom_range(1));
				send_item(CMD_SAMPLE, pick, spot[pick], rand_sample(), 1'($urandom_range(1)));
			end
		end

		sender_idle_pct = 0;
		receiver_stall_pct = 86;
		write_shift(SHIFT_W'(4));
		average_runs(1000, 3, 60);
		write_shift(SHIFT_W'(1));
		average_runs(1100, 16, 6);

		sender_idle_pct = 23;
		receiver_stall_pct = 23;
		write_shift(SHIFT_W'(3));
		average_runs(1230, 10, 20);
		write_shift(SHIFT_W'(15));
		average_runs(1350, 2, 8);

		drain();
		if (mismatch_count == 0)
			$display("PASS trace_ema_averager");
		else
			$display("FAIL trace_ema_averager");
		$finish;
	end

endmodule
